// ===== rtl/core/page_framebuffer_sprite_blit_macros.svh =====
`ifndef PAGE_FRAMEBUFFER_SPRITE_BLIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_SPRITE_BLIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PFSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PFSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfsb_pkg.sv =====
package pfsb_pkg;

  localparam int DISPLAY_WIDTH = 84;
  localparam int DISPLAY_PAGES = 6;
  localparam int FB_SIZE       = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int FB_ADDR_W     = $clog2(FB_SIZE);

  localparam logic ITEM_READ = 1'b1;

  typedef enum logic [2:0] {
    REG_SPRITE_WIDTH = 3'd0,
    REG_SPRITE_PAGES = 3'd1,
    REG_X_POSITION   = 3'd2,
    REG_Y_POSITION   = 3'd3,
    REG_XOR_MODE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MERGE_A,
    ST_MERGE_B
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_read;
    logic load_byte;
    logic merge_a;
    logic merge_b;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic clear_last;
  } status_t;

endpackage

// ===== rtl/core/page_framebuffer_sprite_blit.sv =====
// channel  | direction | handshake                 | payload
// item     | in        | start & !busy             | kind, sprite_byte, first_of_draw,
//          |           |                           | read_address
// result   | out       | done, one cycle           | read_data
// config   | in        | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// after reset a clearing pass zeroes the 504-byte frame store, one byte a cycle, with busy
// high throughout; config writes are taken during it
// a read item does not hold busy; its byte shows on read_data with done in the next cycle,
// and another item may be accepted in that cycle
// a sprite byte is accepted and then goes through two read-modify-write merges (ST_MERGE_A,
// ST_MERGE_B) through the one write port of the frame store; a byte past the sprite height is accepted with no merge
// the receiver cannot stall: done is high for exactly one cycle per read item
module page_framebuffer_sprite_blit
  import pfsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       kind,
  input  logic [7:0] sprite_byte,
  input  logic       first_of_draw,
  input  logic [8:0] read_address,
  output logic       done,
  output logic [7:0] read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pfsb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  pfsb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sprite_byte   (sprite_byte),
    .first_of_draw (first_of_draw),
    .read_address  (read_address),
    .cmd           (cmd),
    .status        (status),
    .read_data     (read_data)
  );

endmodule

// ===== rtl/core/pfsb_ram.sv =====
module pfsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pfsb_dp.sv =====
module pfsb_dp
  import pfsb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic [7:0]   sprite_byte,
  input  logic         first_of_draw,
  input  logic [8:0]   read_address,
  input  cmd_t         cmd,
  output status_t      status,
  output logic [7:0]   read_data
);

  logic [7:0] sprite_width;
  logic [3:0] sprite_pages;
  logic [7:0] x_position;
  logic [6:0] y_position;
  logic       xor_mode;

  logic [6:0] column_count;
  logic [3:0] page_count;
  logic [FB_ADDR_W-1:0] clr_count;

  logic [FB_ADDR_W-1:0] addr_a;
  logic [FB_ADDR_W-1:0] addr_b;
  logic                 hit_a;
  logic                 hit_b;
  logic [7:0]           bits_a;
  logic [7:0]           bits_b;
  logic                 read_hit;

  logic [6:0]           cc_eff;
  logic [3:0]           pc_eff;
  logic signed [9:0]    col_pos;
  logic signed [5:0]    page_pos;
  logic signed [5:0]    page_below;
  logic                 col_ok;
  logic                 hit_a_next;
  logic                 hit_b_next;
  logic [FB_ADDR_W-1:0] addr_a_next;
  logic [15:0]          shifted;
  logic                 wrap;

  logic                 ram_we;
  logic [FB_ADDR_W-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [FB_ADDR_W-1:0] ram_raddr;
  logic [7:0]           ram_rdata;
  logic [7:0]           merge_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width <= 8'd1;
      sprite_pages <= 4'd1;
      x_position   <= 8'd0;
      y_position   <= 7'd0;
      xor_mode     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPRITE_WIDTH: sprite_width <= cfg_data;
        REG_SPRITE_PAGES: sprite_pages <= cfg_data[3:0];
        REG_X_POSITION:   x_position   <= cfg_data;
        REG_Y_POSITION:   y_position   <= cfg_data[6:0];
        REG_XOR_MODE:     xor_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // counters restart at the sprite origin before the byte is placed
  assign cc_eff = first_of_draw ? 7'd0 : column_count;
  assign pc_eff = first_of_draw ? 4'd0 : page_count;
  assign status.drop = (pc_eff >= sprite_pages);
  assign status.clear_last = (clr_count == FB_ADDR_W'(FB_SIZE - 1));

  // floor(y / 8) is the arithmetic shift of the signed row
  assign col_pos    = {{2{x_position[7]}}, x_position} + {3'b000, cc_eff};
  assign page_pos   = {{2{y_position[6]}}, y_position[6:3]} + {2'b00, pc_eff};
  assign page_below = page_pos + 6'sd1;

  assign col_ok     = !col_pos[9] && (col_pos < 10'(DISPLAY_WIDTH));
  assign hit_a_next = col_ok && !page_pos[5] && (page_pos < 6'(DISPLAY_PAGES));
  assign hit_b_next = col_ok && !page_below[5] && (page_below < 6'(DISPLAY_PAGES));

  assign addr_a_next = FB_ADDR_W'(col_pos) + FB_ADDR_W'(page_pos * DISPLAY_WIDTH);
  assign shifted     = {8'h00, sprite_byte} << y_position[2:0];

  assign wrap = (({1'b0, cc_eff} + 8'd1) >= sprite_width) || (cc_eff == 7'd127);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 7'd0;
      page_count   <= 4'd0;
      clr_count    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_count <= clr_count + FB_ADDR_W'(1);
      end
      if (cmd.load_byte) begin
        if (status.drop) begin
          column_count <= cc_eff;
          page_count   <= pc_eff;
        end else if (wrap) begin
          column_count <= 7'd0;
          page_count   <= pc_eff + 4'd1;
        end else begin
          column_count <= cc_eff + 7'd1;
          page_count   <= pc_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      addr_a <= addr_a_next;
      addr_b <= addr_a_next + FB_ADDR_W'(DISPLAY_WIDTH);
      hit_a  <= hit_a_next;
      hit_b  <= hit_b_next;
      bits_a <= shifted[7:0];
      bits_b <= shifted[15:8];
    end
    if (cmd.load_read) begin
      read_hit <= (int'(read_address) < FB_SIZE);
    end
  end

  // first byte is fetched in the accept cycle, the second during the first write-back
  always_comb begin
    ram_raddr = addr_a_next;
    if (cmd.load_read) begin
      ram_raddr = FB_ADDR_W'(read_address);
    end else if (cmd.merge_a) begin
      ram_raddr = addr_b;
    end
  end

  assign merge_bits = cmd.merge_a ? bits_a : bits_b;
  assign ram_we     = cmd.clr_step || (cmd.merge_a && hit_a) || (cmd.merge_b && hit_b);
  assign ram_waddr  = cmd.clr_step ? clr_count : (cmd.merge_a ? addr_a : addr_b);

  always_comb begin
    if (cmd.clr_step) begin
      ram_wdata = 8'h00;
    end else if (xor_mode) begin
      ram_wdata = ram_rdata ^ merge_bits;
    end else begin
      ram_wdata = ram_rdata | merge_bits;
    end
  end

  pfsb_ram #(
    .WIDTH (8),
    .DEPTH (FB_SIZE)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign read_data = read_hit ? ram_rdata : 8'h00;

endmodule

// ===== rtl/core/pfsb_ctrl.sv =====
`include "page_framebuffer_sprite_blit_macros.svh"

module pfsb_ctrl
  import pfsb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    kind,
  input  status_t status,
  output logic    busy,
  output logic    done,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE, ST_READ: begin
        state_next = ST_IDLE;
        if (accept) begin
          if (kind == ITEM_READ) begin
            state_next = ST_READ;
          end else if (!status.drop) begin
            state_next = ST_MERGE_A;
          end
        end
      end
      ST_MERGE_A: state_next = ST_MERGE_B;
      ST_MERGE_B: state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_CLEAR:   cmd.clr_step = 1'b1;
      ST_IDLE:    busy = 1'b0;
      ST_READ: begin
        busy = 1'b0;
        done = 1'b1;
      end
      ST_MERGE_A: cmd.merge_a = 1'b1;
      ST_MERGE_B: cmd.merge_b = 1'b1;
      default: ;
    endcase
    cmd.load_read = start && !busy && (kind == ITEM_READ);
    cmd.load_byte = start && !busy && (kind != ITEM_READ);
  end

  `PFSB_ASSERT_NEXT(a_read_result, start && !busy && kind == ITEM_READ, done,
                    "read transfer did not return its byte in the next cycle")
  `PFSB_ASSERT_NEXT(a_second_merge, cmd.merge_a, cmd.merge_b && busy,
                    "second write-back did not follow the first")
  `PFSB_ASSERT_NOW(a_clear_quiet, state == ST_CLEAR,
                   busy && !done && !cmd.load_read && !cmd.load_byte,
                   "transfer taken during the clearing pass")
  `PFSB_ASSERT_NOW(a_one_mem_user, cmd.clr_step || cmd.merge_a || cmd.merge_b,
                   !cmd.load_read && !cmd.load_byte,
                   "new item accepted while the memory port is in use")

endmodule
